>>> rtl/core/plfr_pkg.sv
// Shared constants, types and address helpers of the line rasterizer.
`default_nettype none
package plfr_pkg;

   // Framebuffer geometry: pages of eight rows, one byte per column and page.
   localparam int COLUMNS       = 128;
   localparam int PAGES         = 8;
   localparam int ROWS_PER_PAGE = 8;
   localparam int DEPTH         = PAGES * COLUMNS;
   localparam int ADDR_W        = $clog2(DEPTH);

   // Field widths of the request and response beats.
   localparam int COL_W  = 7;
   localparam int ROW_W  = 6;
   localparam int BIT_W  = $clog2(ROWS_PER_PAGE);
   localparam int PAGE_W = ROW_W - BIT_W;
   localparam int BYTE_W = ROWS_PER_PAGE;

   // Error term of the stepper: covers -2*major .. 2*minor for 7-bit spans.
   localparam int ERR_W = COL_W + 3;

   // One point of the line as it leaves the stepper.
   typedef struct packed {
      logic             vld;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             last;
      logic             ink;
   } pt_type;

   // Control from the pixel unit back to the stepper.
   typedef struct packed {
      logic advance;
      logic clearing;
   } ctl_type;

   function automatic logic [PAGE_W-1:0] page_of(input logic [ROW_W-1:0] row);
      page_of = row[ROW_W-1:BIT_W];
   endfunction

   function automatic logic in_range(input logic [COL_W-1:0] col,
                                     input logic [ROW_W-1:0] row);
      in_range = (int'(col) < COLUMNS) && (int'(row[ROW_W-1:BIT_W]) < PAGES);
   endfunction

   function automatic logic [ADDR_W-1:0] addr_of(input logic [COL_W-1:0] col,
                                                 input logic [ROW_W-1:0] row);
      addr_of = ADDR_W'(int'(row[ROW_W-1:BIT_W]) * COLUMNS + int'(col));
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/plfr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module plfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> rtl/core/plfr_stepper.sv
// Bresenham stepper: a setup state, then one point per advancing cycle.
`default_nettype none
module plfr_stepper (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [plfr_pkg::COL_W-1:0] req_x_start,
   input  wire logic [plfr_pkg::ROW_W-1:0] req_y_start,
   input  wire logic [plfr_pkg::COL_W-1:0] req_x_end,
   input  wire logic [plfr_pkg::ROW_W-1:0] req_y_end,
   input  wire logic                      req_ink,
   input  wire plfr_pkg::ctl_type         ctl,
   output plfr_pkg::pt_type               pt
);

   typedef enum logic [1:0] {ST_IDLE, ST_SETUP, ST_RUN} state_type;

   state_type                      state_ff;
   logic [plfr_pkg::COL_W-1:0]     x_ff, xe_ff;
   logic [plfr_pkg::ROW_W-1:0]     y_ff, ye_ff;
   logic                           ink_ff;
   logic                           step_x_ff, sx_neg_ff, sy_neg_ff;
   logic [plfr_pkg::COL_W-1:0]     rem_ff;
   logic signed [plfr_pkg::ERR_W-1:0] err_ff, inc_a_ff, inc_b_ff;

   logic [plfr_pkg::COL_W:0]       dx;
   logic [plfr_pkg::ROW_W:0]       dy;
   logic [plfr_pkg::COL_W-1:0]     adx, major, minor;
   logic [plfr_pkg::ROW_W-1:0]     ady;
   logic                           step_x;
   logic signed [plfr_pkg::ERR_W-1:0] two_minor, two_major, major_e, err_init, inc_b;
   logic                           err_ge, move_x, move_y, accept;
   logic signed [plfr_pkg::ERR_W-1:0] err_in;
   logic [plfr_pkg::COL_W-1:0]     x_in;
   logic [plfr_pkg::ROW_W-1:0]     y_in;

   assign req_stall = (state_ff != ST_IDLE) || ctl.clearing;
   assign accept    = req_valid && !req_stall;

   // Setup arithmetic: spans, directions, major axis and error increments.
   always_comb begin
      dx        = {1'b0, xe_ff} - {1'b0, x_ff};
      dy        = {1'b0, ye_ff} - {1'b0, y_ff};
      adx       = dx[plfr_pkg::COL_W] ? plfr_pkg::COL_W'(-dx) : dx[plfr_pkg::COL_W-1:0];
      ady       = dy[plfr_pkg::ROW_W] ? plfr_pkg::ROW_W'(-dy) : dy[plfr_pkg::ROW_W-1:0];
      step_x    = adx > {1'b0, ady};
      major     = step_x ? adx : {1'b0, ady};
      minor     = step_x ? {1'b0, ady} : adx;
      two_minor = {2'b00, minor, 1'b0};
      two_major = {2'b00, major, 1'b0};
      major_e   = {3'b000, major};
      err_init  = two_minor - major_e;
      inc_b     = two_minor - two_major;
   end

   // The shared step unit: one error add and the coordinate moves.
   always_comb begin
      err_ge = !err_ff[plfr_pkg::ERR_W-1];
      err_in = err_ff + (err_ge ? inc_b_ff : inc_a_ff);
      move_x = step_x_ff || err_ge;
      move_y = !step_x_ff || err_ge;
      x_in   = x_ff;
      y_in   = y_ff;
      if (move_x) begin
         x_in = sx_neg_ff ? x_ff - plfr_pkg::COL_W'(1) : x_ff + plfr_pkg::COL_W'(1);
      end
      if (move_y) begin
         y_in = sy_neg_ff ? y_ff - plfr_pkg::ROW_W'(1) : y_ff + plfr_pkg::ROW_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  x_ff     <= req_x_start;
                  y_ff     <= req_y_start;
                  xe_ff    <= req_x_end;
                  ye_ff    <= req_y_end;
                  ink_ff   <= req_ink;
                  state_ff <= ST_SETUP;
               end
            end
            ST_SETUP: begin
               step_x_ff <= step_x;
               sx_neg_ff <= dx[plfr_pkg::COL_W];
               sy_neg_ff <= dy[plfr_pkg::ROW_W];
               rem_ff    <= major;
               err_ff    <= err_init;
               inc_a_ff  <= two_minor;
               inc_b_ff  <= inc_b;
               state_ff  <= ST_RUN;
            end
            ST_RUN: begin
               if (ctl.advance) begin
                  x_ff   <= x_in;
                  y_ff   <= y_in;
                  err_ff <= err_in;
                  rem_ff <= rem_ff - plfr_pkg::COL_W'(1);
                  if (rem_ff == '0) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_comb begin
      pt.vld  = (state_ff == ST_RUN);
      pt.col  = x_ff;
      pt.row  = y_ff;
      pt.last = (rem_ff == '0);
      pt.ink  = ink_ff;
   end

endmodule
`default_nettype wire

>>> rtl/core/plfr_pixel.sv
// Pixel unit: framebuffer read-modify-write, clearing sweep, pairing, output register.
`default_nettype none
module plfr_pixel (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire plfr_pkg::pt_type            pt,
   output plfr_pkg::ctl_type                ctl,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [plfr_pkg::PAGE_W-1:0]      rsp_first_page,
   output logic [plfr_pkg::COL_W-1:0]       rsp_first_column,
   output logic [plfr_pkg::BYTE_W-1:0]      rsp_first_byte,
   output logic                             rsp_second_valid,
   output logic [plfr_pkg::PAGE_W-1:0]      rsp_second_page,
   output logic [plfr_pkg::COL_W-1:0]       rsp_second_column,
   output logic [plfr_pkg::BYTE_W-1:0]      rsp_second_byte,
   output logic                             rsp_last
);

   localparam int AW = plfr_pkg::ADDR_W;

   // Control registers.
   logic          clearing_ff;
   logic [AW-1:0] clr_cnt_ff;
   logic          b_vld_ff, have_first_ff, fwd_vld_ff, rsp_valid_ff;

   // Payload registers.
   logic [plfr_pkg::COL_W-1:0]  b_col_ff;
   logic [plfr_pkg::ROW_W-1:0]  b_row_ff;
   logic                        b_last_ff, b_ink_ff, b_inr_ff;
   logic [AW-1:0]               b_addr_ff, fwd_addr_ff;
   logic [plfr_pkg::BYTE_W-1:0] fwd_byte_ff;
   logic [plfr_pkg::PAGE_W-1:0] f_page_ff;
   logic [plfr_pkg::COL_W-1:0]  f_col_ff;
   logic [plfr_pkg::BYTE_W-1:0] f_byte_ff;
   logic [plfr_pkg::PAGE_W-1:0] o_fpage_ff, o_spage_ff;
   logic [plfr_pkg::COL_W-1:0]  o_fcol_ff, o_scol_ff;
   logic [plfr_pkg::BYTE_W-1:0] o_fbyte_ff, o_sbyte_ff;
   logic                        o_svld_ff, o_last_ff;

   logic [AW-1:0]               rd_addr, wr_addr;
   logic [plfr_pkg::BYTE_W-1:0] rd_data, wr_data, old_byte, mask, new_byte, rep_byte;
   logic                        wr_en, completes, hold, take, wr_pt;

   // While the held point waits, its own byte is read again so that the read data
   // still belongs to it when the pipeline moves on.
   assign rd_addr = hold ? b_addr_ff : plfr_pkg::addr_of(pt.col, pt.row);

   always_comb begin
      // The previous write may not be visible in the read data yet.
      old_byte  = (fwd_vld_ff && (fwd_addr_ff == b_addr_ff)) ? fwd_byte_ff : rd_data;
      mask      = plfr_pkg::BYTE_W'(1) << b_row_ff[plfr_pkg::BIT_W-1:0];
      new_byte  = b_ink_ff ? (old_byte | mask) : (old_byte & ~mask);
      rep_byte  = b_inr_ff ? new_byte : '0;
      completes = b_vld_ff && (have_first_ff || b_last_ff);
      hold      = completes && rsp_valid_ff && rsp_stall;
      take      = b_vld_ff && !hold;
      wr_pt     = take && b_inr_ff;
      wr_en     = clearing_ff || wr_pt;
      wr_addr   = clearing_ff ? clr_cnt_ff : b_addr_ff;
      wr_data   = clearing_ff ? '0 : new_byte;
   end

   assign ctl.advance  = !hold;
   assign ctl.clearing = clearing_ff;

   plfr_ram #(
      .WIDTH (plfr_pkg::BYTE_W),
      .DEPTH (plfr_pkg::DEPTH)
   ) u_frame (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clr_cnt_ff    <= '0;
         b_vld_ff      <= 1'b0;
         have_first_ff <= 1'b0;
         fwd_vld_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (clearing_ff) begin
            clr_cnt_ff <= clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == AW'(plfr_pkg::DEPTH - 1)) begin
               clearing_ff <= 1'b0;
            end
         end
         if (!hold) begin
            b_vld_ff <= pt.vld;
         end
         if (wr_pt) begin
            fwd_vld_ff <= 1'b1;
         end
         if (take && completes) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (take) begin
            have_first_ff <= !completes;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!hold) begin
         b_col_ff  <= pt.col;
         b_row_ff  <= pt.row;
         b_last_ff <= pt.last;
         b_ink_ff  <= pt.ink;
         b_inr_ff  <= plfr_pkg::in_range(pt.col, pt.row);
         b_addr_ff <= rd_addr;
      end
      if (wr_pt) begin
         fwd_addr_ff <= b_addr_ff;
         fwd_byte_ff <= new_byte;
      end
      if (take) begin
         if (completes) begin
            o_last_ff <= b_last_ff;
            if (have_first_ff) begin
               o_fpage_ff <= f_page_ff;
               o_fcol_ff  <= f_col_ff;
               o_fbyte_ff <= f_byte_ff;
               o_svld_ff  <= 1'b1;
               o_spage_ff <= plfr_pkg::page_of(b_row_ff);
               o_scol_ff  <= b_col_ff;
               o_sbyte_ff <= rep_byte;
            end else begin
               o_fpage_ff <= plfr_pkg::page_of(b_row_ff);
               o_fcol_ff  <= b_col_ff;
               o_fbyte_ff <= rep_byte;
               o_svld_ff  <= 1'b0;
               o_spage_ff <= '0;
               o_scol_ff  <= '0;
               o_sbyte_ff <= '0;
            end
         end else begin
            f_page_ff <= plfr_pkg::page_of(b_row_ff);
            f_col_ff  <= b_col_ff;
            f_byte_ff <= rep_byte;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_first_page    = o_fpage_ff;
   assign rsp_first_column  = o_fcol_ff;
   assign rsp_first_byte    = o_fbyte_ff;
   assign rsp_second_valid  = o_svld_ff;
   assign rsp_second_page   = o_spage_ff;
   assign rsp_second_column = o_scol_ff;
   assign rsp_second_byte   = o_sbyte_ff;
   assign rsp_last          = o_last_ff;

endmodule
`default_nettype wire

>>> rtl/core/page_framebuffer_line_rasterizer_unit.sv
// Top level of the line rasterizer into a page-organized 1-bit framebuffer.
//
// A request beat carries two endpoints and an ink bit. The block walks the line
// with Bresenham stepping along the major axis (a tie steps y), updates one bit
// of the framebuffer per point, and reports the points two per response beat in
// drawing order. The final beat of a line has last set; with an odd point count
// its second slot is marked empty and reads as zero.
// After a request beat is taken, req_stall stays high until the line's last
// point has left the stepper: a setup state, then one point per cycle through
// the stepper's error adder and the framebuffer's read-modify-write port, as
// long as the pixel unit does not hold the stepper for a stalled response.
// After reset the framebuffer is swept to zero, one byte per cycle, through all
// 1024 bytes; req_stall stays high during the sweep.
// When the receiver raises rsp_stall while a beat waits, the point pipeline
// freezes once the next beat is complete, and resumes without loss.
`default_nettype none
module page_framebuffer_line_rasterizer_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [plfr_pkg::COL_W-1:0]  req_x_start,
   input  wire logic [plfr_pkg::ROW_W-1:0]  req_y_start,
   input  wire logic [plfr_pkg::COL_W-1:0]  req_x_end,
   input  wire logic [plfr_pkg::ROW_W-1:0]  req_y_end,
   input  wire logic                        req_ink,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [plfr_pkg::PAGE_W-1:0]      rsp_first_page,
   output logic [plfr_pkg::COL_W-1:0]       rsp_first_column,
   output logic [plfr_pkg::BYTE_W-1:0]      rsp_first_byte,
   output logic                             rsp_second_valid,
   output logic [plfr_pkg::PAGE_W-1:0]      rsp_second_page,
   output logic [plfr_pkg::COL_W-1:0]       rsp_second_column,
   output logic [plfr_pkg::BYTE_W-1:0]      rsp_second_byte,
   output logic                             rsp_last
);

   // Point stream from the stepper and back-pressure from the pixel unit.
   plfr_pkg::pt_type  pt;
   plfr_pkg::ctl_type ctl;

   // The stepper holds the line's geometry and advances one point whenever the
   // pixel unit can take it.
   plfr_stepper u_stepper (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_x_start (req_x_start),
      .req_y_start (req_y_start),
      .req_x_end   (req_x_end),
      .req_y_end   (req_y_end),
      .req_ink     (req_ink),
      .ctl         (ctl),
      .pt          (pt)
   );

   // The pixel unit owns the framebuffer, forwards the last written byte so that
   // back-to-back points on one byte see each other, and pairs points into beats.
   plfr_pixel u_pixel (
      .clock             (clock),
      .reset             (reset),
      .pt                (pt),
      .ctl               (ctl),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_first_page    (rsp_first_page),
      .rsp_first_column  (rsp_first_column),
      .rsp_first_byte    (rsp_first_byte),
      .rsp_second_valid  (rsp_second_valid),
      .rsp_second_page   (rsp_second_page),
      .rsp_second_column (rsp_second_column),
      .rsp_second_byte   (rsp_second_byte),
      .rsp_last          (rsp_last)
   );

endmodule
`default_nettype wire

>>> sim/tb_page_framebuffer_line_rasterizer_unit.sv
// Self-checking testbench for the page framebuffer line rasterizer unit.
module tb_page_framebuffer_line_rasterizer_unit;
   timeunit 1ns;
   timeprecision 1ps;

   // Geometry and field widths of the block.
   localparam int COL_W         = plfr_pkg::COL_W;
   localparam int ROW_W         = plfr_pkg::ROW_W;
   localparam int PAGE_W        = plfr_pkg::PAGE_W;
   localparam int BYTE_W        = plfr_pkg::BYTE_W;
   localparam int COLUMNS       = plfr_pkg::COLUMNS;
   localparam int PAGES         = plfr_pkg::PAGES;
   localparam int ROWS_PER_PAGE = plfr_pkg::ROWS_PER_PAGE;
   localparam int DEPTH         = plfr_pkg::DEPTH;

   // One response beat: two pixel updates of the line, in drawing order.
   typedef struct packed {
      logic [PAGE_W-1:0] first_page;
      logic [COL_W-1:0]  first_column;
      logic [BYTE_W-1:0] first_byte;
      logic              second_valid;
      logic [PAGE_W-1:0] second_page;
      logic [COL_W-1:0]  second_column;
      logic [BYTE_W-1:0] second_byte;
      logic              last;
   } pixel_pair_type;

   // One line request. When typed is set, want holds the single beat that the
   // line must produce, written out by hand; otherwise the predictor decides.
   typedef struct packed {
      logic [COL_W-1:0] xs;
      logic [ROW_W-1:0] ys;
      logic [COL_W-1:0] xe;
      logic [ROW_W-1:0] ye;
      logic             ink;
      logic             typed;
      pixel_pair_type   want;
   } line_row_type;

   localparam int MAX_POINTS    = 128;
   localparam int X_TOP         = (1 << COL_W) - 1;
   localparam int Y_TOP         = (1 << ROW_W) - 1;
   localparam int RANDOM_LINES  = 440;
   localparam int LONG_HOLD_AT  = 150;  // random line at which the receiver holds off
   localparam int LONG_HOLD     = 400;  // length of that hold-off in cycles
   localparam int CALM_FROM     = 380;  // from here on neither side idles
   localparam int DRAIN_CYCLES  = 32;

   localparam pixel_pair_type NO_PAIR = '0;

   // The directed lines. The first four are single points whose bytes follow
   // directly from a cleared screen: set a corner, clear it again.
   localparam int DIRECTED_ROWS = 21;
   line_row_type directed_rows [DIRECTED_ROWS] = '{
      // Top-left corner set, right after reset.
      '{7'd0, 6'd0, 7'd0, 6'd0, 1'b1, 1'b1,
        '{3'd0, 7'd0, 8'h01, 1'b0, 3'd0, 7'd0, 8'h00, 1'b1}},
      // Bottom-right corner set: top bit of the last page.
      '{7'd127, 6'd63, 7'd127, 6'd63, 1'b1, 1'b1,
        '{3'd7, 7'd127, 8'h80, 1'b0, 3'd0, 7'd0, 8'h00, 1'b1}},
      // Both corners cleared again.
      '{7'd127, 6'd63, 7'd127, 6'd63, 1'b0, 1'b1,
        '{3'd7, 7'd127, 8'h00, 1'b0, 3'd0, 7'd0, 8'h00, 1'b1}},
      '{7'd0, 6'd0, 7'd0, 6'd0, 1'b0, 1'b1,
        '{3'd0, 7'd0, 8'h00, 1'b0, 3'd0, 7'd0, 8'h00, 1'b1}},
      // Full-width and full-height lines, both directions, set and clear.
      '{7'd0,   6'd0,  7'd127, 6'd0,  1'b1, 1'b0, NO_PAIR},
      '{7'd127, 6'd63, 7'd0,   6'd63, 1'b1, 1'b0, NO_PAIR},
      '{7'd0,   6'd0,  7'd0,   6'd63, 1'b1, 1'b0, NO_PAIR},
      '{7'd127, 6'd63, 7'd127, 6'd0,  1'b0, 1'b0, NO_PAIR},
      // Exact diagonals: a tie between the spans steps y.
      '{7'd0,   6'd0,  7'd63,  6'd63, 1'b1, 1'b0, NO_PAIR},
      '{7'd127, 6'd0,  7'd64,  6'd63, 1'b1, 1'b0, NO_PAIR},
      // Corner to corner, x-major, then back with clearing ink.
      '{7'd0,   6'd0,  7'd127, 6'd63, 1'b1, 1'b0, NO_PAIR},
      '{7'd127, 6'd63, 7'd0,   6'd0,  1'b0, 1'b0, NO_PAIR},
      // Two points (even count), three points (odd count, empty second slot).
      '{7'd5,   6'd10, 7'd6,   6'd10, 1'b1, 1'b0, NO_PAIR},
      '{7'd5,   6'd10, 7'd7,   6'd10, 1'b1, 1'b0, NO_PAIR},
      // Vertical run inside one byte: the second byte includes the first update.
      '{7'd20,  6'd2,  7'd20,  6'd5,  1'b1, 1'b0, NO_PAIR},
      // Vertical run across a page boundary.
      '{7'd30,  6'd7,  7'd30,  6'd8,  1'b1, 1'b0, NO_PAIR},
      // Steep line with a minor span of one, and a shallow one that clears.
      '{7'd40,  6'd0,  7'd41,  6'd63, 1'b1, 1'b0, NO_PAIR},
      '{7'd0,   6'd31, 7'd127, 6'd32, 1'b0, 1'b0, NO_PAIR},
      // Single point on a byte that earlier lines may have touched.
      '{7'd64,  6'd32, 7'd64,  6'd32, 1'b1, 1'b0, NO_PAIR},
      // General slopes, including a tie with y falling.
      '{7'd100, 6'd50, 7'd3,   6'd9,  1'b1, 1'b0, NO_PAIR},
      '{7'd90,  6'd12, 7'd97,  6'd5,  1'b1, 1'b0, NO_PAIR}
   };

   logic                clock;
   logic                reset             = 1'b1;
   logic                req_valid         = 1'b0;
   logic                req_stall;
   logic [COL_W-1:0]    req_x_start       = '0;
   logic [ROW_W-1:0]    req_y_start       = '0;
   logic [COL_W-1:0]    req_x_end         = '0;
   logic [ROW_W-1:0]    req_y_end         = '0;
   logic                req_ink           = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall         = 1'b0;
   logic [PAGE_W-1:0]   rsp_first_page;
   logic [COL_W-1:0]    rsp_first_column;
   logic [BYTE_W-1:0]   rsp_first_byte;
   logic                rsp_second_valid;
   logic [PAGE_W-1:0]   rsp_second_page;
   logic [COL_W-1:0]    rsp_second_column;
   logic [BYTE_W-1:0]   rsp_second_byte;
   logic                rsp_last;

   // Predicted screen contents, indexed page * COLUMNS + column, clear at reset.
   logic [BYTE_W-1:0]   screen_bytes [DEPTH] = '{default: '0};

   // Beats the current line produces, and all beats still owed by the block.
   pixel_pair_type      line_pairs [$];
   pixel_pair_type      pairs_due [$];
   pixel_pair_type      wanted;

   int                  mismatches     = 0;
   bit                  long_hold_req  = 1'b0;
   bit                  long_hold_done = 1'b0;
   bit                  calm           = 1'b0;

   page_framebuffer_line_rasterizer_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_x_start       (req_x_start),
      .req_y_start       (req_y_start),
      .req_x_end         (req_x_end),
      .req_y_end         (req_y_end),
      .req_ink           (req_ink),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_first_page    (rsp_first_page),
      .rsp_first_column  (rsp_first_column),
      .rsp_first_byte    (rsp_first_byte),
      .rsp_second_valid  (rsp_second_valid),
      .rsp_second_page   (rsp_second_page),
      .rsp_second_column (rsp_second_column),
      .rsp_second_byte   (rsp_second_byte),
      .rsp_last          (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Sets or clears one pixel of the predicted screen and returns the byte that
   // holds it afterwards. A point off the screen writes nothing and reads zero.
   function automatic logic [BYTE_W-1:0] paint(input int col, input int row,
                                               input logic ink);
      int                idx;
      logic [BYTE_W-1:0] mask;
      if (col >= COLUMNS || row / ROWS_PER_PAGE >= PAGES) return '0;
      idx  = (row / ROWS_PER_PAGE) * COLUMNS + col;
      mask = BYTE_W'(1) << (row % ROWS_PER_PAGE);
      if (ink) screen_bytes[idx] = screen_bytes[idx] | mask;
      else     screen_bytes[idx] = screen_bytes[idx] & ~mask;
      return screen_bytes[idx];
   endfunction

   // Walks one line with Bresenham stepping along the longer span and fills
   // line_pairs with the beats it should produce, painting the screen as it goes.
   function automatic void rasterize_line(input logic [COL_W-1:0] xs,
                                          input logic [ROW_W-1:0] ys,
                                          input logic [COL_W-1:0] xe,
                                          input logic [ROW_W-1:0] ye,
                                          input logic ink);
      int             x, y, dx, dy, sx, sy, major, minor, err, n, k, beats;
      bit             step_x;
      int             px [MAX_POINTS];
      int             py [MAX_POINTS];
      pixel_pair_type pair;
      x  = int'(xs);
      y  = int'(ys);
      dx = int'(xe) - x;
      dy = int'(ye) - y;
      sx = 1;
      sy = 1;
      if (dx < 0) begin
         dx = -dx;
         sx = -1;
      end
      if (dy < 0) begin
         dy = -dy;
         sy = -1;
      end
      // A tie between the spans steps y.
      step_x = dx > dy;
      major  = step_x ? dx : dy;
      minor  = step_x ? dy : dx;
      err    = 2 * minor - major;
      n      = (major + 1 > MAX_POINTS) ? MAX_POINTS : major + 1;
      for (int i = 0; i < n; i++) begin
         px[i] = x;
         py[i] = y;
         // The error is tested before twice the minor span is added to it.
         if (err >= 0) begin
            err -= 2 * major;
            if (step_x) y += sy;
            else        x += sx;
         end
         err += 2 * minor;
         if (step_x) x += sx;
         else        y += sy;
      end
      line_pairs.delete();
      beats = (n + 1) / 2;
      for (k = 0; k < beats; k++) begin
         pair              = '0;
         pair.first_page   = PAGE_W'((py[2*k] & Y_TOP) / ROWS_PER_PAGE);
         pair.first_column = COL_W'(px[2*k]);
         pair.first_byte   = paint(px[2*k] & X_TOP, py[2*k] & Y_TOP, ink);
         // An odd point count leaves the second slot of the final beat empty.
         if (2 * k + 1 < n) begin
            pair.second_valid  = 1'b1;
            pair.second_page   = PAGE_W'((py[2*k+1] & Y_TOP) / ROWS_PER_PAGE);
            pair.second_column = COL_W'(px[2*k+1]);
            pair.second_byte   = paint(px[2*k+1] & X_TOP, py[2*k+1] & Y_TOP, ink);
         end
         pair.last = (k == beats - 1);
         line_pairs.push_back(pair);
      end
   endfunction

   // Picks a random line. Short lines are common so that many lines fit in the
   // run, with points, axis-aligned runs, exact diagonals and full random spans
   // mixed in. Ink mostly sets, so the clearing lines find bits to remove.
   function automatic line_row_type random_line();
      line_row_type r;
      int           xs, ys, xe, ye, d, kind;
      r    = '0;
      xs   = $urandom_range(0, X_TOP);
      ys   = $urandom_range(0, Y_TOP);
      xe   = $urandom_range(0, X_TOP);
      ye   = $urandom_range(0, Y_TOP);
      kind = $urandom_range(0, 9);
      case (kind)
         0: begin
            xe = xs;
            ye = ys;
         end
         1: ye = ys;
         2: xe = xs;
         3: begin
            d  = $urandom_range(0, Y_TOP);
            xe = xs + (($urandom_range(0, 1) != 0) ? d : -d);
            ye = ys + (($urandom_range(0, 1) != 0) ? d : -d);
         end
         4, 5, 6: begin
            xe = xs + $urandom_range(0, 12) - 6;
            ye = ys + $urandom_range(0, 12) - 6;
         end
         default: ;
      endcase
      // Mirror an end point that fell off the screen about the start point.
      if (xe < 0 || xe > X_TOP) xe = 2 * xs - xe;
      if (ye < 0 || ye > Y_TOP) ye = 2 * ys - ye;
      r.xs  = COL_W'(xs);
      r.ys  = ROW_W'(ys);
      r.xe  = COL_W'(xe);
      r.ye  = ROW_W'(ye);
      r.ink = ($urandom_range(0, 9) < 7);
      return r;
   endfunction

   // Offers one line until the block takes it, records the beats it owes, and
   // sometimes lets the request channel go quiet for a while afterwards.
   task automatic offer_line(input line_row_type row);
      req_x_start <= row.xs;
      req_y_start <= row.ys;
      req_x_end   <= row.xe;
      req_y_end   <= row.ye;
      req_ink     <= row.ink;
      req_valid   <= 1'b1;
      do @(posedge clock); while (req_stall);
      rasterize_line(row.xs, row.ys, row.xe, row.ye, row.ink);
      if (row.typed) pairs_due.push_back(row.want);
      else foreach (line_pairs[i]) pairs_due.push_back(line_pairs[i]);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Request side. Reset is held at the start; the block then sweeps its
   // framebuffer clear with req_stall high, which the handshake simply waits out.
   initial begin
      int idx;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (idx = 0; idx < DIRECTED_ROWS; idx++) offer_line(directed_rows[idx]);
      // Let the block drain completely before the random lines start.
      req_valid <= 1'b0;
      while (pairs_due.size() != 0) @(posedge clock);
      @(posedge clock);
      for (idx = 0; idx < RANDOM_LINES; idx++) begin
         // The receiver holds off for a long stretch while lines keep coming,
         // so the block fills up and stalls the request channel.
         if (idx == LONG_HOLD_AT) long_hold_req = 1'b1;
         if (idx == CALM_FROM) calm = 1'b1;
         offer_line(random_line());
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (pairs_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Response side. A new stall rate is drawn whenever the window counter runs
   // out, zero among the choices, so that quiet stretches alternate with stalled
   // bursts of random length. The long hold-off is counted here, apart from the request side.
   initial begin
      int window, odds, held;
      window = 0;
      odds   = 0;
      forever begin
         @(posedge clock);
         if (window == 0) begin
            window = 64;
            odds   = $urandom_range(0, 3);
         end
         window--;
         if (long_hold_req && !long_hold_done) begin
            rsp_stall <= 1'b1;
            held = 0;
            while (held < LONG_HOLD) begin
               @(posedge clock);
               held++;
            end
            rsp_stall      <= 1'b0;
            long_hold_done = 1'b1;
         end else if (!calm && odds != 0 && $urandom_range(0, 7) < odds) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Each accepted response beat is held against the oldest beat still owed.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pairs_due.size() == 0) begin
            $display("%0t ns: response beat with none expected, expected nothing, got %h",
                     $time, {rsp_first_page, rsp_first_column, rsp_first_byte,
                             rsp_second_valid, rsp_second_page, rsp_second_column,
                             rsp_second_byte, rsp_last});
            mismatches++;
         end else begin
            wanted = pairs_due.pop_front();
            check_field("first_page",    32'(wanted.first_page),    32'(rsp_first_page));
            check_field("first_column",  32'(wanted.first_column),  32'(rsp_first_column));
            check_field("first_byte",    32'(wanted.first_byte),    32'(rsp_first_byte));
            check_field("second_valid",  32'(wanted.second_valid),  32'(rsp_second_valid));
            check_field("second_page",   32'(wanted.second_page),   32'(rsp_second_page));
            check_field("second_column", 32'(wanted.second_column), 32'(rsp_second_column));
            check_field("second_byte",   32'(wanted.second_byte),   32'(rsp_second_byte));
            check_field("last",          32'(wanted.last),          32'(rsp_last));
         end
      end
   end

   // Watchdog, far beyond the slowest legal run: clearing sweep, every line at
   // full length, every beat stalled and every gap at its longest.
   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/plfr_pkg.sv
rtl/core/plfr_ram.sv
rtl/core/plfr_stepper.sv
rtl/core/plfr_pixel.sv
rtl/core/page_framebuffer_line_rasterizer_unit.sv
sim/tb_page_framebuffer_line_rasterizer_unit.sv
